// ----- rtl/core/gnbc_pkg.sv -----
// Shared types, codes and the face pattern table of the grid node boundary classifier.
// No dependencies; used by gnbc_kind and grid_node_boundary_classifier.
package gnbc_pkg;

	typedef enum logic [1:0] {
		OP_WRITE    = 2'd0,
		OP_CLASSIFY = 2'd1,
		OP_READ     = 2'd2,
		OP_NONE     = 2'd3
	} op_t;

	typedef enum logic [3:0] {
		NT_INVALID     = 4'd0,
		NT_INTERNAL    = 4'd1,
		NT_BOTTOMLEFT  = 4'd2,
		NT_UPPERLEFT   = 4'd3,
		NT_LEFT        = 4'd4,
		NT_BOTTOMRIGHT = 4'd5,
		NT_UPPERRIGHT  = 4'd6,
		NT_RIGHT       = 4'd7,
		NT_BOTTOM      = 4'd8,
		NT_UP          = 4'd9
	} node_type_t;

	localparam logic CFG_ROWS = 1'b0;
	localparam logic CFG_COLS = 1'b1;

	// edge position of a node inside the active grid
	typedef struct packed {
		logic top;
		logic bot;
		logic lft;
		logic rgt;
	} node_pos_t;

	// faces: bit3 (m,n), bit2 (m-1,n), bit1 (m-1,n-1), bit0 (m,n-1)
	function automatic node_type_t face_type(input logic [3:0] k);
		node_type_t t;
		case (k)
			4'd1:    t = NT_UPPERLEFT;
			4'd2:    t = NT_UPPERRIGHT;
			4'd3:    t = NT_UP;
			4'd4:    t = NT_BOTTOMRIGHT;
			4'd6:    t = NT_RIGHT;
			4'd7:    t = NT_BOTTOMLEFT;
			4'd8:    t = NT_BOTTOMLEFT;
			4'd9:    t = NT_LEFT;
			4'd11:   t = NT_BOTTOMRIGHT;
			4'd12:   t = NT_BOTTOM;
			4'd13:   t = NT_UPPERRIGHT;
			4'd14:   t = NT_UPPERLEFT;
			4'd15:   t = NT_INTERNAL;
			default: t = NT_INVALID;
		endcase
		return t;
	endfunction

endpackage

// ----- rtl/core/gnbc_kind.sv -----
// Boundary type of one valid node from its edge position, neighbors and faces.
// Depends on gnbc_pkg.
module gnbc_kind
	import gnbc_pkg::*;
(
	input  node_pos_t  pos,
	input  logic       va,
	input  logic       vb,
	input  logic [3:0] faces,
	output node_type_t kind
);

	always_comb begin
		if (pos.top) begin
			if (pos.lft)              kind = NT_BOTTOMLEFT;
			else if (pos.rgt)         kind = NT_UPPERLEFT;
			else if (!va)             kind = NT_BOTTOMLEFT;
			else if (!vb)             kind = NT_UPPERLEFT;
			else                      kind = NT_LEFT;
		end else if (pos.bot) begin
			if (pos.lft)              kind = NT_BOTTOMRIGHT;
			else if (pos.rgt)         kind = NT_UPPERRIGHT;
			else if (!va)             kind = NT_BOTTOMRIGHT;
			else if (!vb)             kind = NT_UPPERRIGHT;
			else                      kind = NT_RIGHT;
		end else if (pos.lft) begin
			if (!va)                  kind = NT_BOTTOMLEFT;
			else if (!vb)             kind = NT_BOTTOMRIGHT;
			else                      kind = NT_BOTTOM;
		end else if (pos.rgt) begin
			if (!va)                  kind = NT_UPPERLEFT;
			else if (!vb)             kind = NT_UPPERRIGHT;
			else                      kind = NT_UP;
		end else begin
			kind = face_type(faces);
		end
	end

endmodule

// ----- rtl/core/grid_node_boundary_classifier.sv -----
// Top level of the grid node boundary classifier: validity, face and type memories
// and the sequencer that walks them. Depends on gnbc_pkg and gnbc_kind.
//
// Write (op 0) commands are taken in the idle state and read (op 2) commands pass
// through a read state; a read result reaches the output register in the cycle
// after its transfer. Classify (op 1) walks the memories with one synchronous read
// per cycle: each face build pass visits every face, each orphan pass every node,
// and the typing sweep every entry of the 2^(clog2(MAX_ROWS)+clog2(MAX_COLS))
// storage, reading neighbors and faces of active nodes; input stalls meanwhile.
// After reset a clearing pass over every entry of the validity and type memories
// runs before the first input transfer; configuration writes are taken at any time.
module grid_node_boundary_classifier
	import gnbc_pkg::*;
#(
	parameter int MAX_ROWS = 64,
	parameter int MAX_COLS = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,   // row_index[5:0], col_index[11:6], node_valid[12], zeros
	input  logic [1:0]  s_tuser,   // op[1:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata,   // node_type[3:0], node_present[4], removed_count[17:5], zeros
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        cfg_index,
	input  logic [6:0]  cfg_data
);

	localparam int RW = $clog2(MAX_ROWS);
	localparam int CW = $clog2(MAX_COLS);
	localparam int AW = RW + CW;
	localparam int DEPTH = 1 << AW;
	localparam logic [2:0] SUB_LAST = 3'd4;

	typedef enum logic [2:0] {
		ST_CLR, ST_IDLE, ST_RD, ST_FACE, ST_ORPH, ST_TYPE
	} state_t;

	typedef enum logic [2:0] {
		CAT_NONE, CAT_INT, CAT_COL0, CAT_ROW0, CAT_ORIG
	} cat_t;

	logic            valid_mem [DEPTH];
	logic            face_mem  [DEPTH];
	logic [3:0]      type_mem  [DEPTH];

	state_t          state_q;
	logic [6:0]      rows_cfg_q, cols_cfg_q;
	logic [RW-1:0]   row_q;
	logic [CW-1:0]   col_q;
	logic [2:0]      sub_q;
	logic            acc_q, self_v_q, va_q, vb_q, again_q;
	logic [2:0]      fb_q;
	logic [12:0]     cnt_q, total_q;
	logic            out_v_q;
	logic [3:0]      out_type_q;
	logic            out_pres_q;
	logic            rd_act_q;

	logic            v_rd_q, f_rd_q;
	logic [3:0]      t_rd_q;

	logic [RW:0]     rows_act, cols_act;
	logic [15:0]     rows_w, cols_w, ri16, ci16;
	logic [RW:0]     r_ext;
	logic [CW:0]     c_ext;
	logic            r_last, c_last, r_pen, c_pen, r_all, c_all, in_act;
	logic [RW-1:0]   rm, rp;
	logic [CW-1:0]   cm, cp;
	logic [AW-1:0]   a_self, in_addr;
	logic            in_store, in_grid, s_xfer;
	op_t             op;
	cat_t            cat;
	logic            use_up, use_left, use_diag, anyf, drop;

	logic [AW-1:0]   v_raddr, f_raddr, v_waddr, t_waddr;
	logic            v_we, f_we, t_we, v_wdata;
	logic [3:0]      t_wdata;
	node_pos_t       pos;
	node_type_t      kind;

	assign rows_w = 16'(rows_cfg_q);
	assign cols_w = 16'(cols_cfg_q);
	assign rows_act = (rows_w < 16'd2) ? (RW+1)'(2) :
		(rows_w > 16'(MAX_ROWS)) ? (RW+1)'(MAX_ROWS) : rows_w[RW:0];
	assign cols_act = (cols_w < 16'd2) ? (CW+1)'(2) :
		(cols_w > 16'(MAX_COLS)) ? (CW+1)'(MAX_COLS) : cols_w[CW:0];

	assign r_ext  = {1'b0, row_q};
	assign c_ext  = {1'b0, col_q};
	assign r_last = r_ext == rows_act - (RW+1)'(1);
	assign c_last = c_ext == cols_act - (CW+1)'(1);
	assign r_pen  = r_ext == rows_act - (RW+1)'(2);
	assign c_pen  = c_ext == cols_act - (CW+1)'(2);
	assign r_all  = &row_q;
	assign c_all  = &col_q;
	assign in_act = (r_ext < rows_act) && (c_ext < cols_act);
	assign rm = row_q - RW'(1);
	assign rp = row_q + RW'(1);
	assign cm = col_q - CW'(1);
	assign cp = col_q + CW'(1);
	assign a_self = {row_q, col_q};

	assign op       = op_t'(s_tuser);
	assign ri16     = 16'(s_tdata[5:0]);
	assign ci16     = 16'(s_tdata[11:6]);
	assign in_store = (ri16 < 16'(MAX_ROWS)) && (ci16 < 16'(MAX_COLS));
	assign in_grid  = (ri16 < 16'(rows_act)) && (ci16 < 16'(cols_act));
	assign in_addr  = {ri16[RW-1:0], ci16[CW-1:0]};
	assign s_tready = (state_q == ST_IDLE) && (!out_v_q || m_tready);
	assign s_xfer   = s_tvalid && s_tready;
	assign cfg_ready = 1'b1;

	always_comb begin
		if (row_q == '0 && col_q == '0)      cat = CAT_ORIG;
		else if (r_last || c_last)           cat = CAT_NONE;
		else if (row_q == '0)                cat = CAT_ROW0;
		else if (col_q == '0)                cat = CAT_COL0;
		else                                 cat = CAT_INT;
	end

	always_comb begin
		if (state_q == ST_TYPE) begin
			use_up = 1'b1; use_left = 1'b1; use_diag = 1'b1;
		end else begin
			use_up   = (cat == CAT_INT) || (cat == CAT_COL0);
			use_left = (cat == CAT_INT) || (cat == CAT_ROW0);
			use_diag = cat == CAT_INT;
		end
	end

	always_comb begin
		v_raddr = a_self;
		f_raddr = a_self;
		unique case (state_q)
			ST_IDLE: v_raddr = in_addr;
			ST_FACE: begin
				case (sub_q)
					3'd0:    v_raddr = {row_q, col_q};
					3'd1:    v_raddr = {rp, col_q};
					3'd2:    v_raddr = {row_q, cp};
					default: v_raddr = {rp, cp};
				endcase
			end
			ST_ORPH, ST_TYPE: begin
				case (sub_q)
					3'd1:    f_raddr = use_up   ? {rm, col_q} : a_self;
					3'd2:    f_raddr = use_diag ? {rm, cm}    : a_self;
					3'd3:    f_raddr = use_left ? {row_q, cm} : a_self;
					default: f_raddr = a_self;
				endcase
				if (state_q == ST_TYPE) begin
					case (sub_q)
						3'd1:    v_raddr = (row_q == '0 || r_last) ? {row_q, cm} : {rm, col_q};
						3'd2:    v_raddr = (row_q == '0 || r_last) ? {row_q, cp} : {rp, col_q};
						default: v_raddr = a_self;
					endcase
				end
			end
			default: v_raddr = a_self;
		endcase
	end

	assign anyf = acc_q | f_rd_q;
	assign drop = self_v_q && !anyf;

	assign pos.top = row_q == '0;
	assign pos.bot = r_last;
	assign pos.lft = col_q == '0;
	assign pos.rgt = c_last;

	gnbc_kind u_kind (
		.pos   (pos),
		.va    (va_q),
		.vb    (vb_q),
		.faces ({fb_q, f_rd_q}),
		.kind  (kind)
	);

	always_comb begin
		v_we = 1'b0; v_waddr = a_self; v_wdata = 1'b0;
		f_we = 1'b0;
		t_we = 1'b0; t_waddr = a_self; t_wdata = NT_INVALID;
		unique case (state_q)
			ST_CLR: begin
				v_we = 1'b1;
				t_we = 1'b1;
			end
			ST_IDLE: begin
				v_we    = s_xfer && op == OP_WRITE && in_store;
				v_waddr = in_addr;
				v_wdata = s_tdata[12];
			end
			ST_FACE: f_we = sub_q == SUB_LAST;
			ST_ORPH: v_we = sub_q == SUB_LAST && drop;
			ST_TYPE: begin
				t_we    = !in_act || sub_q == SUB_LAST;
				t_wdata = (in_act && self_v_q) ? 4'(kind) : 4'(NT_INVALID);
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (v_we) valid_mem[v_waddr] <= v_wdata;
		if (f_we) face_mem[a_self] <= acc_q & v_rd_q;
		if (t_we) type_mem[t_waddr] <= t_wdata;
		v_rd_q <= valid_mem[v_raddr];
		f_rd_q <= face_mem[f_raddr];
		t_rd_q <= type_mem[in_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_CLR;
			rows_cfg_q <= 7'd64;
			cols_cfg_q <= 7'd64;
			row_q      <= '0;
			col_q      <= '0;
			sub_q      <= '0;
			acc_q      <= 1'b0;
			self_v_q   <= 1'b0;
			va_q       <= 1'b0;
			vb_q       <= 1'b0;
			fb_q       <= '0;
			again_q    <= 1'b0;
			cnt_q      <= '0;
			total_q    <= '0;
			out_v_q    <= 1'b0;
			out_type_q <= '0;
			out_pres_q <= 1'b0;
			rd_act_q   <= 1'b0;
		end else begin
			if (cfg_valid) begin
				if (cfg_index == CFG_ROWS) rows_cfg_q <= cfg_data;
				else                       cols_cfg_q <= cfg_data;
			end
			if (m_tready) out_v_q <= 1'b0;

			unique case (state_q)
				ST_CLR: begin
					col_q <= cp;
					if (c_all) begin
						row_q <= rp;
						if (r_all) state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					row_q <= '0;
					col_q <= '0;
					sub_q <= '0;
					if (s_xfer) begin
						if (op == OP_READ) begin
							rd_act_q <= in_grid;
							state_q  <= ST_RD;
						end else if (op == OP_CLASSIFY) begin
							cnt_q   <= '0;
							state_q <= ST_FACE;
						end
					end
				end
				ST_RD: begin
					out_v_q    <= 1'b1;
					out_type_q <= rd_act_q ? t_rd_q : 4'(NT_INVALID);
					out_pres_q <= rd_act_q & v_rd_q;
					state_q    <= ST_IDLE;
				end
				ST_FACE: begin
					if (sub_q == 3'd0) acc_q <= 1'b1;
					else               acc_q <= acc_q & v_rd_q;
					sub_q <= sub_q + 3'd1;
					if (sub_q == SUB_LAST) begin
						sub_q <= '0;
						col_q <= cp;
						if (c_pen) begin
							col_q <= '0;
							row_q <= rp;
							if (r_pen) begin
								row_q   <= '0;
								again_q <= 1'b0;
								state_q <= ST_ORPH;
							end
						end
					end
				end
				ST_ORPH: begin
					if (cat == CAT_NONE || sub_q == SUB_LAST) begin
						sub_q <= '0;
						if (cat != CAT_NONE && drop) begin
							cnt_q <= cnt_q + 13'd1;
							if (cat == CAT_INT) again_q <= 1'b1;
						end
						col_q <= cp;
						if (c_last) begin
							col_q <= '0;
							row_q <= rp;
							if (r_last) begin
								row_q <= '0;
								if (again_q || (cat == CAT_INT && drop)) begin
									state_q <= ST_FACE;
								end else begin
									total_q <= cnt_q;
									state_q <= ST_TYPE;
								end
							end
						end
					end else begin
						sub_q <= sub_q + 3'd1;
						if (sub_q == 3'd1) begin
							self_v_q <= v_rd_q;
							acc_q    <= f_rd_q;
						end else if (sub_q != 3'd0) begin
							acc_q <= acc_q | f_rd_q;
						end
					end
				end
				ST_TYPE: begin
					if (!in_act || sub_q == SUB_LAST) begin
						sub_q <= '0;
						col_q <= cp;
						if (c_all) begin
							row_q <= rp;
							if (r_all) begin
								out_v_q    <= 1'b1;
								out_type_q <= NT_INVALID;
								out_pres_q <= 1'b0;
								state_q    <= ST_IDLE;
							end
						end
					end else begin
						sub_q <= sub_q + 3'd1;
						if (sub_q != 3'd0) fb_q <= {fb_q[1:0], f_rd_q};
						if (sub_q == 3'd1) self_v_q <= v_rd_q;
						if (sub_q == 3'd2) va_q <= v_rd_q;
						if (sub_q == 3'd3) vb_q <= v_rd_q;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign m_tvalid = out_v_q;
	assign m_tdata  = {6'd0, total_q, out_pres_q, out_type_q};

endmodule
